@@ hw/rtl/release_table_lookup_macros.svh @@
// ---------------------------------------------------------------------------
// release table lookup assertion macros
// shared property forms for the release table lookup block
// ---------------------------------------------------------------------------
`ifndef RELEASE_TABLE_LOOKUP_MACROS_SVH
`define RELEASE_TABLE_LOOKUP_MACROS_SVH

// same-cycle implication
`define RTLK_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("release table lookup same-cycle check failed");

// next-cycle implication
`define RTLK_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("release table lookup next-cycle check failed");

`endif

@@ hw/rtl/rtlk_pkg.sv @@
// ---------------------------------------------------------------------------
// release table lookup package
// widths, constants and controller/datapath interface types
// ---------------------------------------------------------------------------
package rtlk_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = 7;
   localparam int TAPS        = 8;
   localparam logic [47:0] TAPS_Q16 = 48'(TAPS * 65536);

   localparam int PROD_W    = 72;
   localparam int DVS_W     = 50;
   localparam int QUO_W     = 24;
   localparam int MUL_STEPS = 22;
   localparam int DIV_STEPS = PROD_W;
   localparam int STEP_W    = 7;

   localparam logic [QUO_W-1:0] QUOT_CAP = 24'h800000;
   localparam logic signed [25:0] GAIN_MAX = 26'sd1048575;
   localparam logic signed [25:0] GAIN_MIN = -26'sd1048576;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   typedef struct packed {
      logic [31:0]        period;
      logic [47:0]        offset;
      logic [7:0]         source_id;
      logic signed [23:0] error;
      logic signed [20:0] gain;
      logic [31:0]        end_sample;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic              lk_start;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_idx;
      logic              miss;
      logic              hit;
      logic              gain_entry;
      logic              mul_step;
      logic              div_load_gain;
      logic              div_load_mod;
      logic              div_step;
      logic [STEP_W-1:0] bit_idx;
      logic              gain_quot;
      logic              out_load;
   } cmd_type;

   typedef struct packed {
      logic pos_le_end;
      logic span_zero;
      logic period_zero;
      logic rsp_busy;
   } stat_type;

endpackage

@@ hw/rtl/release_table_lookup.sv @@
// ---------------------------------------------------------------------------
// release table lookup
// Stream in table writes and lookups on req_*, results leave on rsp_*.
// req_tuser selects the beat kind: 0 writes one entry, 1 looks up a position.
// A write gives no result; a lookup gives one rsp beat and holds off new
// req beats until its result is loaded. A lookup reads one entry after
// the other until the end sample covers the position or the last entry
// is reached, then runs a 22-step shift-add multiply and a 72-step
// restoring divide for the gain (skipped on the first entry or a zero
// span), then a second 72-step divide on the same divider for the wrap.
// csr_* sets entry_count; write it only while no lookup is open.
// Reset returns the controller to idle, clears the result valid flag and
// sets entry_count to 1; table contents stay undefined until written.
// The result sits in an output register; a stalled receiver holds it and the
// next lookup runs up to its result, then waits for the register to drain.
// ---------------------------------------------------------------------------
`include "release_table_lookup_macros.svh"

module release_table_lookup (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // entry_index, new_end_sample, new_gain, new_error, new_source_id,
   // new_offset, new_period, sample_pos, zero pad
   input  logic [223:0] req_tdata,
   // req_type
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // release_pos, out_gain, out_error, out_source_id, zero pad
   output logic [87:0]  rsp_tdata,
   // period_fault
   output logic         rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [6:0]   csr_data
);

   rtlk_pkg::cmd_type   cmd;
   rtlk_pkg::stat_type  stat;
   rtlk_pkg::entry_type wr_entry;
   logic [32:0]         release_pos;
   logic signed [20:0]  out_gain;
   logic signed [23:0]  out_error;
   logic [7:0]          out_source_id;
   logic                period_fault;

   assign wr_entry.end_sample = req_tdata[37:6];
   assign wr_entry.gain       = req_tdata[58:38];
   assign wr_entry.error      = req_tdata[82:59];
   assign wr_entry.source_id  = req_tdata[90:83];
   assign wr_entry.offset     = req_tdata[138:91];
   assign wr_entry.period     = req_tdata[170:139];

   rtlk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .stat       (stat),
      .cmd        (cmd)
   );

   rtlk_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .wr_idx        (req_tdata[5:0]),
      .wr_entry      (wr_entry),
      .sample_pos    (req_tdata[218:171]),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .release_pos   (release_pos),
      .out_gain      (out_gain),
      .out_error     (out_error),
      .out_source_id (out_source_id),
      .period_fault  (period_fault)
   );

   assign rsp_tdata = {2'b00, out_source_id, out_error, out_gain, release_pos};
   assign rsp_tuser = period_fault;

   `RTLK_ASSERT_NEXT(a_busy_after_lookup, req_tvalid && req_tready && req_tuser == rtlk_pkg::REQ_LOOKUP, !req_tready)
   `RTLK_ASSERT_IMPL(a_fault_zero_pos, rsp_tvalid && rsp_tuser, rsp_tdata[32:0] == 33'd0)
   `RTLK_ASSERT_IMPL(a_pos_floor, rsp_tvalid && !rsp_tuser, rsp_tdata[32:0] >= 33'(rtlk_pkg::TAPS_Q16))

endmodule

@@ hw/rtl/rtlk_ctrl.sv @@
// ---------------------------------------------------------------------------
// release table lookup controller
// sequences table search, gain interpolation and position wrap
// ---------------------------------------------------------------------------
module rtlk_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_tuser,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rtlk_pkg::CNT_W-1:0]    csr_data,
   input  rtlk_pkg::stat_type            stat,
   output rtlk_pkg::cmd_type             cmd
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RD   = 4'd1;
   localparam logic [3:0] ST_CHK  = 4'd2;
   localparam logic [3:0] ST_MUL  = 4'd3;
   localparam logic [3:0] ST_DIVL = 4'd4;
   localparam logic [3:0] ST_DIV  = 4'd5;
   localparam logic [3:0] ST_GAIN = 4'd6;
   localparam logic [3:0] ST_MODL = 4'd7;
   localparam logic [3:0] ST_MOD  = 4'd8;
   localparam logic [3:0] ST_OUT  = 4'd9;

   logic [3:0]                    state_ff, state_in;
   logic [rtlk_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [rtlk_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [rtlk_pkg::CNT_W-1:0]    count_ff;
   logic [rtlk_pkg::CNT_W-1:0]    cnt_eff;
   logic                          last;
   logic                          accept;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (count_ff == '0) begin
         cnt_eff = rtlk_pkg::CNT_W'(1);
      end else if (count_ff > rtlk_pkg::CNT_W'(rtlk_pkg::MAX_ENTRIES)) begin
         cnt_eff = rtlk_pkg::CNT_W'(rtlk_pkg::MAX_ENTRIES);
      end else begin
         cnt_eff = count_ff;
      end
   end

   assign last = ({1'b0, idx_ff} == (cnt_eff - rtlk_pkg::CNT_W'(1)));

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.rd_idx  = idx_ff;
      cmd.bit_idx = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == rtlk_pkg::REQ_WRITE) begin
                  cmd.wr_en = 1'b1;
               end else begin
                  cmd.lk_start = 1'b1;
                  idx_in   = '0;
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_CHK;
         end
         ST_CHK: begin
            if (stat.pos_le_end || last) begin
               cmd.hit = 1'b1;
               if (idx_ff == '0 || stat.span_zero) begin
                  cmd.gain_entry = 1'b1;
                  state_in = ST_MODL;
               end else begin
                  step_in  = '0;
                  state_in = ST_MUL;
               end
            end else begin
               cmd.miss = 1'b1;
               idx_in   = idx_ff + rtlk_pkg::IDX_W'(1);
               state_in = ST_RD;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            step_in = step_ff + rtlk_pkg::STEP_W'(1);
            if (step_ff == rtlk_pkg::STEP_W'(rtlk_pkg::MUL_STEPS - 1)) begin
               state_in = ST_DIVL;
            end
         end
         ST_DIVL: begin
            cmd.div_load_gain = 1'b1;
            step_in  = rtlk_pkg::STEP_W'(rtlk_pkg::DIV_STEPS - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in = step_ff - rtlk_pkg::STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            cmd.gain_quot = 1'b1;
            state_in = ST_MODL;
         end
         ST_MODL: begin
            if (stat.period_zero) begin
               state_in = ST_OUT;
            end else begin
               cmd.div_load_mod = 1'b1;
               step_in  = rtlk_pkg::STEP_W'(rtlk_pkg::DIV_STEPS - 1);
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            cmd.div_step = 1'b1;
            step_in = step_ff - rtlk_pkg::STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!stat.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= rtlk_pkg::CNT_W'(1);
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_data;
         end
      end
      idx_ff  <= idx_in;
      step_ff <= step_in;
   end

endmodule

@@ hw/rtl/rtlk_dp.sv @@
// ---------------------------------------------------------------------------
// release table lookup datapath
// entry memory, shift-add multiplier, restoring divider and result register
// ---------------------------------------------------------------------------
module rtlk_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  rtlk_pkg::cmd_type           cmd,
   output rtlk_pkg::stat_type          stat,
   input  logic [rtlk_pkg::IDX_W-1:0]  wr_idx,
   input  rtlk_pkg::entry_type         wr_entry,
   input  logic [47:0]                 sample_pos,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [32:0]                 release_pos,
   output logic signed [20:0]          out_gain,
   output logic signed [23:0]          out_error,
   output logic [7:0]                  out_source_id,
   output logic                        period_fault
);

   rtlk_pkg::entry_type mem [rtlk_pkg::MAX_ENTRIES];
   rtlk_pkg::entry_type rd_ff, prev_ff, cur_ff;

   logic [47:0]                       pos_ff;
   logic [rtlk_pkg::PROD_W-1:0]       prod_ff, mcand_ff, dvd_ff;
   logic [21:0]                       mplr_ff;
   logic [rtlk_pkg::DVS_W-1:0]        dvs_ff, ac_ff, rem_ff;
   logic [rtlk_pkg::QUO_W-1:0]        quo_ff;
   logic                              over_ff, neg_ff, tneg_ff;
   logic [49:0]                       tabs_ff;
   logic signed [20:0]                gain_ff;
   logic                              rsp_valid_ff;
   logic [32:0]                       rpos_ff;
   logic signed [20:0]                ogain_ff;
   logic signed [23:0]                oerr_ff;
   logic [7:0]                        osid_ff;
   logic                              ofault_ff;

   logic signed [33:0]                span;
   logic signed [49:0]                d_val, t_val;
   logic signed [21:0]                g_val;
   logic [49:0]                       ad;
   logic [21:0]                       ag;
   logic [32:0]                       aspan;
   logic [rtlk_pkg::DVS_W:0]          rem_t;
   logic                              ge;
   logic [rtlk_pkg::QUO_W-1:0]        q_cap;
   logic signed [25:0]                sgx, gsum;
   logic [31:0]                       r_val, m_val;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_idx] <= wr_entry;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[cmd.rd_idx];
      end
   end

   assign span  = $signed({2'b00, rd_ff.end_sample}) - $signed({2'b00, prev_ff.end_sample})
                  - 34'sd1;
   assign d_val = $signed({2'b00, pos_ff})
                  - $signed({1'b0, 33'({1'b0, prev_ff.end_sample} + 33'd1), 16'h0000});
   assign g_val = $signed({rd_ff.gain[20], rd_ff.gain}) - $signed({prev_ff.gain[20], prev_ff.gain});
   assign t_val = $signed({2'b00, pos_ff}) - $signed({2'b00, rd_ff.offset})
                  - $signed({2'b00, rtlk_pkg::TAPS_Q16});
   assign ad    = d_val[49] ? 50'(-d_val) : 50'(d_val);
   assign ag    = g_val[21] ? 22'(-g_val) : 22'(g_val);
   assign aspan = span[33] ? 33'(-span) : 33'(span);

   assign stat.pos_le_end  = ({2'b00, pos_ff} <= {2'b00, rd_ff.end_sample, 16'h0000});
   assign stat.span_zero   = (span == '0);
   assign stat.period_zero = (cur_ff.period == '0);
   assign stat.rsp_busy    = rsp_valid_ff;

   assign rem_t = {rem_ff, dvd_ff[rtlk_pkg::PROD_W-1]};
   assign ge    = (rem_t >= {1'b0, dvs_ff});

   assign q_cap = (over_ff || quo_ff > rtlk_pkg::QUOT_CAP) ? rtlk_pkg::QUOT_CAP : quo_ff;
   assign sgx   = 26'(prev_ff.gain);
   assign gsum  = neg_ff ? sgx - $signed({2'b00, q_cap}) : sgx + $signed({2'b00, q_cap});

   assign r_val = rem_ff[31:0];
   assign m_val = (tneg_ff && r_val != '0) ? cur_ff.period - r_val : r_val;

   always_ff @(posedge clock) begin
      if (cmd.lk_start) begin
         pos_ff <= sample_pos;
      end
      if (cmd.miss) begin
         prev_ff <= rd_ff;
      end
      if (cmd.hit) begin
         cur_ff   <= rd_ff;
         neg_ff   <= d_val[49] ^ g_val[21] ^ span[33];
         ac_ff    <= {aspan, 16'h0000} & {rtlk_pkg::DVS_W{1'b1}};
         tneg_ff  <= t_val[49];
         tabs_ff  <= t_val[49] ? 50'(-t_val) : 50'(t_val);
         prod_ff  <= '0;
         mcand_ff <= rtlk_pkg::PROD_W'(ad);
         mplr_ff  <= ag;
      end
      if (cmd.gain_entry) begin
         gain_ff <= rd_ff.gain;
      end
      if (cmd.mul_step) begin
         if (mplr_ff[0]) begin
            prod_ff <= prod_ff + mcand_ff;
         end
         mcand_ff <= mcand_ff << 1;
         mplr_ff  <= mplr_ff >> 1;
      end
      if (cmd.div_load_gain || cmd.div_load_mod) begin
         dvd_ff  <= cmd.div_load_gain ? prod_ff : rtlk_pkg::PROD_W'(tabs_ff);
         dvs_ff  <= cmd.div_load_gain ? ac_ff : rtlk_pkg::DVS_W'(cur_ff.period);
         rem_ff  <= '0;
         quo_ff  <= '0;
         over_ff <= 1'b0;
      end
      if (cmd.div_step) begin
         dvd_ff <= dvd_ff << 1;
         rem_ff <= ge ? rtlk_pkg::DVS_W'(rem_t - {1'b0, dvs_ff})
                      : rem_t[rtlk_pkg::DVS_W-1:0];
         if (ge) begin
            if (cmd.bit_idx >= rtlk_pkg::STEP_W'(rtlk_pkg::QUO_W)) begin
               over_ff <= 1'b1;
            end else begin
               quo_ff[cmd.bit_idx[4:0]] <= 1'b1;
            end
         end
      end
      if (cmd.gain_quot) begin
         if (gsum > rtlk_pkg::GAIN_MAX) begin
            gain_ff <= 21'(rtlk_pkg::GAIN_MAX);
         end else if (gsum < rtlk_pkg::GAIN_MIN) begin
            gain_ff <= 21'(rtlk_pkg::GAIN_MIN);
         end else begin
            gain_ff <= gsum[20:0];
         end
      end
      if (cmd.out_load) begin
         rpos_ff   <= (cur_ff.period == '0) ? 33'd0
                      : 33'(rtlk_pkg::TAPS_Q16) + {1'b0, m_val};
         ogain_ff  <= gain_ff;
         oerr_ff   <= cur_ff.error;
         osid_ff   <= cur_ff.source_id;
         ofault_ff <= (cur_ff.period == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign release_pos   = rpos_ff;
   assign out_gain      = ogain_ff;
   assign out_error     = oerr_ff;
   assign out_source_id = osid_ff;
   assign period_fault  = ofault_ff;

endmodule

@@ tb/tb.sv @@
// ---------------------------------------------------------------------------
// release table lookup testbench
// Loads the entry table through req beats with sorted, unsorted and
// degenerate end samples, sets entry_count across its range and checks
// every lookup result against an in-bench model of search, gain
// interpolation with saturation and wrap of the release position.
// ---------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        kind;
      logic [5:0]  idx;
      logic [31:0] end_s;
      logic [20:0] gain;
      logic [23:0] err;
      logic [7:0]  sid;
      logic [47:0] off;
      logic [31:0] per;
      logic [47:0] pos;
   } req_item_type;

   typedef struct packed {
      logic [32:0] rpos;
      logic [20:0] gain;
      logic [23:0] err;
      logic [7:0]  sid;
      logic        fault;
   } lookup_result_type;

   class release_scoreboard;
      logic [31:0] end_s[rtlk_pkg::MAX_ENTRIES];
      logic signed [20:0] gain[rtlk_pkg::MAX_ENTRIES];
      logic [23:0] err[rtlk_pkg::MAX_ENTRIES];
      logic [7:0]  sid[rtlk_pkg::MAX_ENTRIES];
      logic [47:0] off[rtlk_pkg::MAX_ENTRIES];
      logic [31:0] per[rtlk_pkg::MAX_ENTRIES];
      logic [6:0]  entry_count = 7'd1;
      lookup_result_type pending_results[$];
      int mismatches = 0;
      int lookups = 0;
      int writes = 0;

      function int active_entries();
         if (entry_count == 0) return 1;
         if (entry_count > rtlk_pkg::MAX_ENTRIES) return rtlk_pkg::MAX_ENTRIES;
         return int'(entry_count);
      endfunction

      function lookup_result_type predict_lookup(logic [47:0] pos);
         lookup_result_type r;
         int i;
         int cnt;
         longint sg, eg, ss, es, span, d, gd, g, tmp, q;
         longint unsigned ad, ag, ac;
         logic [127:0] quot;
         bit neg;
         cnt = active_entries();
         i = 0;
         while (i + 1 < cnt && !(pos <= {end_s[i], 16'h0})) i++;
         if (i == 0) begin
            g = longint'(gain[0]);
         end else begin
            sg = longint'(gain[i-1]);
            eg = longint'(gain[i]);
            ss = longint'({32'h0, end_s[i-1]});
            es = longint'({32'h0, end_s[i]});
            span = es - ss - 1;
            if (span == 0) begin
               g = eg;
            end else begin
               d = longint'({16'h0, pos}) - (ss + 1) * 65536;
               gd = eg - sg;
               neg = (d < 0) != (gd < 0);
               ad = d < 0 ? -d : d;
               ag = gd < 0 ? -gd : gd;
               ac = (span < 0 ? -span : span) << 16;
               if (span < 0) neg = !neg;
               quot = (128'(ad) * 128'(ag)) / 128'(ac);
               q = quot > 128'(rtlk_pkg::QUOT_CAP) ? longint'({40'h0, rtlk_pkg::QUOT_CAP})
                                                   : longint'(quot[63:0]);
               g = neg ? sg - q : sg + q;
            end
            if (g > longint'(rtlk_pkg::GAIN_MAX)) g = longint'(rtlk_pkg::GAIN_MAX);
            if (g < longint'(rtlk_pkg::GAIN_MIN)) g = longint'(rtlk_pkg::GAIN_MIN);
         end
         r.gain = g[20:0];
         r.err = err[i];
         r.sid = sid[i];
         r.fault = per[i] == 0;
         if (per[i] == 0) begin
            r.rpos = '0;
         end else begin
            tmp = longint'({16'h0, pos}) - longint'({16'h0, off[i]})
                  - longint'(rtlk_pkg::TAPS) * 65536;
            tmp = tmp % longint'({32'h0, per[i]});
            if (tmp < 0) tmp += longint'({32'h0, per[i]});
            tmp = longint'(rtlk_pkg::TAPS) * 65536 + tmp;
            r.rpos = tmp[32:0];
         end
         return r;
      endfunction

      function void note_request(req_item_type it);
         if (it.kind == rtlk_pkg::REQ_WRITE) begin
            writes++;
            end_s[it.idx] = it.end_s;
            gain[it.idx] = it.gain;
            err[it.idx] = it.err;
            sid[it.idx] = it.sid;
            off[it.idx] = it.off;
            per[it.idx] = it.per;
         end else begin
            lookups++;
            pending_results.push_back(predict_lookup(it.pos));
         end
      endfunction

      function void check_result(logic [87:0] data, logic fault);
         lookup_result_type e, a;
         a.rpos = data[32:0];
         a.gain = data[53:33];
         a.err = data[77:54];
         a.sid = data[85:78];
         a.fault = fault;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result beat with nothing expected: %h", data);
            return;
         end
         e = pending_results.pop_front();
         if (a != e || data[87:86] != 2'b00) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp pos %h gain %h err %h id %h flt %b, got %h %h %h %h %b",
                        e.rpos, e.gain, e.err, e.sid, e.fault,
                        a.rpos, a.gain, a.err, a.sid, a.fault);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [223:0] req_tdata = '0;
   logic req_tuser = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [87:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 0;
   logic csr_ready;
   logic [6:0] csr_data = '0;

   release_scoreboard sb = new();
   bit no_idle = 0;
   int phase_count = 0;

   release_table_lookup DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function int draw_gap();
      return no_idle ? 0 : int'($urandom_range(6));
   endfunction

   task automatic send_beat(req_item_type it);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= it.kind;
      req_tdata <= {5'h0, it.pos, it.per, it.off, it.sid, it.err, it.gain, it.end_s, it.idx};
      do @(posedge clock); while (!req_tready);
      sb.note_request(it);
      @(negedge clock);
   endtask

   task automatic write_count(logic [6:0] v);
      req_tvalid <= 0;
      while (sb.pending_results.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      csr_valid <= 1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      sb.entry_count = v;
      @(negedge clock);
      csr_valid <= 0;
      phase_count++;
   endtask

   function req_item_type rand_entry(logic [5:0] idx, logic [31:0] end_s);
      req_item_type it;
      it.kind = rtlk_pkg::REQ_WRITE;
      it.idx = idx;
      it.end_s = end_s;
      it.gain = 21'($urandom);
      it.err = 24'($urandom);
      it.sid = 8'($urandom);
      it.off = $urandom_range(1) ? 48'({$urandom, $urandom}) : 48'($urandom_range(1 << 24));
      case ($urandom_range(7))
         0: it.per = 0;
         1, 2: it.per = $urandom;
         default: it.per = $urandom_range(1, 1 << $urandom_range(1, 24));
      endcase
      it.pos = 48'({$urandom, $urandom});
      return it;
   endfunction

   function req_item_type rand_lookup();
      req_item_type it;
      int k;
      it = rand_entry(6'($urandom), $urandom);
      it.kind = rtlk_pkg::REQ_LOOKUP;
      k = int'($urandom_range(sb.active_entries() - 1));
      case ($urandom_range(9))
         0: it.pos = 48'({$urandom, $urandom});
         1: it.pos = $urandom_range(1) ? '0 : '1;
         default: it.pos = {sb.end_s[k], 16'h0} + 48'(int'($urandom_range(1 << 20)) - (1 << 19));
      endcase
      return it;
   endfunction

   task automatic fill_table(bit sorted);
      logic [31:0] e;
      e = $urandom_range(1) ? 0 : $urandom;
      for (int k = 0; k < rtlk_pkg::MAX_ENTRIES; k++) begin
         if (!sorted) e = $urandom;
         else if ($urandom_range(4) == 0) e += $urandom_range(2);
         else e += $urandom_range(1, 1 << $urandom_range(1, 20));
         send_beat(rand_entry(6'(k), e));
      end
   endtask

   task automatic directed_part();
      req_item_type it;
      logic [47:0] pos_list[6] = '{48'h0, 48'h1_0000, 48'h64_0000, 48'h65_0000,
                                   48'hC8_8000, 48'hFFFF_FFFF_FFFF};
      write_count(7'd4);
      it = rand_entry(6'd0, 32'd100);
      it.gain = 21'h0FFFFF; it.err = 24'h800000; it.off = '1; it.per = '1;
      send_beat(it);
      it = rand_entry(6'd1, 32'd101);
      it.gain = 21'h100000; it.err = 24'h7FFFFF; it.off = '0; it.per = 0;
      send_beat(it);
      it = rand_entry(6'd2, 32'd300);
      it.gain = 21'h0FFFFF; it.off = '0; it.per = 32'h1;
      send_beat(it);
      it = rand_entry(6'd3, 32'd50);
      it.gain = 21'h100000; it.per = 32'h8_0000;
      send_beat(it);
      for (int k = 0; k < 6; k++) begin
         it = rand_lookup();
         it.pos = pos_list[k];
         send_beat(it);
      end
      write_count(7'd0);
      it.pos = 48'h7FFF_0000;
      send_beat(it);
      write_count(7'd127);
      send_beat(it);
      it.pos = 48'h0;
      send_beat(it);
   endtask

   initial begin
      logic [6:0] counts[8] = '{7'd64, 7'd1, 7'd127, 7'd2, 7'd37, 7'd0, 7'd64, 7'd9};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      fill_table(1);
      directed_part();
      for (int p = 0; p < 8; p++) begin
         no_idle = (p % 3) == 2;
         write_count(p == 7 ? 7'($urandom_range(3, 64)) : counts[p]);
         fill_table(p != 3);
         repeat (140) begin
            if ($urandom_range(9) == 0) send_beat(rand_entry(6'($urandom), $urandom));
            else send_beat(rand_lookup());
         end
      end
      req_tvalid <= 0;
      while (sb.pending_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("covered %0d entry writes and %0d lookups over %0d count settings",
               sb.writes, sb.lookups, phase_count);
      if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      int stall;
      @(negedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_tready <= 0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         sb.check_result(rsp_tdata, rsp_tuser);
         @(negedge clock);
      end
   end

   initial begin
      #30ms;
      $display("timeout");
      $display("Regression FAIL");
      $finish;
   end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/rtlk_pkg.sv
hw/rtl/rtlk_ctrl.sv
hw/rtl/rtlk_dp.sv
hw/rtl/release_table_lookup.sv
tb/tb.sv
